// ===== design/mpl_pkg.sv =====
// shared constants, codes and word types for the completion probability lookup
package mpl_pkg;

    localparam int MAX_STEPS  = 16;
    localparam int MAX_STATES = 64;
    localparam int STEP_W     = $clog2(MAX_STEPS);
    localparam int ROW_W      = $clog2(MAX_STATES);
    localparam int ADDR_W     = STEP_W + ROW_W + 1;
    localparam int DEPTH      = MAX_STEPS * MAX_STATES * 2;

    localparam int Q_W    = 16;
    localparam int DVD_W  = 32;
    localparam int DVS_W  = 16;
    localparam int CNT_W  = $clog2(DVD_W);
    localparam int MCNT_W = $clog2(Q_W);
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [Q_W-1:0] ONE_Q15 = 16'd32768;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_WACK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DIV   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NSTEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GARB  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MSIZE = 3'd4;

    typedef struct packed {
        logic        opcode;
        logic [31:0] window_left;
        logic [15:0] pattern_left;
        logic [3:0]  entry_step;
        logic [5:0]  entry_row;
        logic        entry_col;
        logic [15:0] entry_value;
    } in_t;

    typedef struct packed {
        logic [15:0] probability;
        logic [1:0]  status;
    } out_t;

    typedef struct packed {
        logic             go;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic           go;
        logic [Q_W-1:0] a;
        logic [Q_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic             done;
        logic [2*Q_W-1:0] product;
    } mul_rsp_t;

endpackage

// ===== design/mpl_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module mpl_div (
    input  logic              clk,
    input  logic              rst_n,
    input  mpl_pkg::div_req_t req,
    output mpl_pkg::div_rsp_t rsp
);
    import mpl_pkg::*;

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] rem_next;
    logic [DVD_W-1:0] quo_reg;
    logic [DVD_W-1:0] quo_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             fits;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DVD_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        fits     = shifted >= {1'b0, dvs_reg};
        rem_next = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.go)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == {CNT_W{1'b1}})
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== design/mpl_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
module mpl_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  mpl_pkg::mul_req_t req,
    output mpl_pkg::mul_rsp_t rsp
);
    import mpl_pkg::*;

    logic              run_reg;
    logic              done_reg;
    logic [MCNT_W-1:0] cnt_reg;
    logic [Q_W-1:0]    a_reg;
    logic [2*Q_W-1:0]  prod_reg;
    logic [2*Q_W-1:0]  prod_next;
    logic [Q_W:0]      sum;

    always_comb
    begin
        sum       = {1'b0, prod_reg[2*Q_W-1:Q_W]} + (prod_reg[0] ? {1'b0, a_reg} : '0);
        prod_next = {sum, prod_reg[Q_W-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.go)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == {MCNT_W{1'b1}})
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            a_reg    <= req.a;
            prod_reg <= {{Q_W{1'b0}}, req.b};
        end
        else if (run_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = prod_reg;

endmodule

// ===== design/mpl_table.sv =====
// power table memory, one write port and one registered read port
module mpl_table (
    input  logic                       clk,
    input  logic                       we,
    input  logic [mpl_pkg::ADDR_W-1:0] waddr,
    input  logic [mpl_pkg::Q_W-1:0]    wdata,
    input  logic [mpl_pkg::ADDR_W-1:0] raddr,
    output logic [mpl_pkg::Q_W-1:0]    rdata
);
    import mpl_pkg::*;

    logic [Q_W-1:0] mem [DEPTH];
    logic [Q_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/markov_completion_probability_lookup.sv =====
// top level: command sequencer, configuration registers and result register
//
// a word on cmd is taken at a clock edge with start high and busy low.
// opcode write stores entry_value in the power table and answers with
// status 2 in the next cycle; busy stays low, so writes can go every cycle.
// opcode query scales the counts down on a shared bit-serial divider, picks the table
// step and interpolates with a bit-serial multiplier and one more division.
// a query is answered from the counts alone, from the last step's entry when past it,
// or by interpolating between two steps.
// busy stays high until the result word is shown on result for exactly one
// cycle with done high; the next word can be taken at the edge that ends it.
// the receiver cannot hold results off.
// the user writes configuration through cfg_we, cfg_index and cfg_data while idle;
// the block does not enforce this. reset clears the registers to their defaults and
// marks the table empty; table entries must be written before they are read.
module markov_completion_probability_lookup (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  mpl_pkg::in_t                  cmd,
    output logic                          busy,
    output logic                          done,
    output mpl_pkg::out_t                 result,
    input  logic                          cfg_we,
    input  logic [mpl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mpl_pkg::CFG_W-1:0]     cfg_data
);
    import mpl_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIVW   = 4'd1;
    localparam logic [3:0] S_DIVP   = 4'd2;
    localparam logic [3:0] S_DIVL   = 4'd3;
    localparam logic [3:0] S_RDLAST = 4'd4;
    localparam logic [3:0] S_RDLO   = 4'd5;
    localparam logic [3:0] S_RDUP   = 4'd6;
    localparam logic [3:0] S_MUL    = 4'd7;
    localparam logic [3:0] S_DIVI   = 4'd8;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic              loaded_reg;
    logic              done_reg;
    logic              done_next;
    out_t              result_reg;
    out_t              result_next;

    logic [15:0]       div_reg;
    logic [15:0]       step_reg;
    logic [4:0]        nsteps_reg;
    logic              garb_reg;
    logic [6:0]        msize_reg;

    logic [15:0]       pat_reg;
    logic [15:0]       pat_next;
    logic [DVD_W-1:0]  w_reg;
    logic [DVD_W-1:0]  w_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic              col_reg;
    logic              col_next;
    logic [STEP_W-1:0] lostep_reg;
    logic [STEP_W-1:0] lostep_next;
    logic [Q_W-1:0]    frac_reg;
    logic [Q_W-1:0]    frac_next;
    logic [Q_W-1:0]    lo_reg;
    logic [Q_W-1:0]    lo_next;
    logic              neg_reg;
    logic              neg_next;

    logic [15:0]       dv;
    logic [15:0]       sz;
    logic [STEP_W-1:0] ns_m1;
    logic [16:0]       p_full;
    logic [16:0]       p_adj;
    logic              p_range_ok;
    logic              accept;
    logic              wr_en;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [Q_W-1:0]    rdata;
    logic [Q_W-1:0]    mag;
    logic [Q_W-1:0]    q16;

    div_req_t div_req;
    div_rsp_t div_rsp;
    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    mpl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    mpl_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    mpl_table u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (cmd.entry_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign busy   = state_reg != S_IDLE;
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    // zero counts act as one, step count saturates at the table depth
    always_comb
    begin
        dv = (div_reg == '0) ? 16'd1 : div_reg;
        sz = (step_reg == '0) ? 16'd1 : step_reg;
        if (nsteps_reg == '0)
        begin
            ns_m1 = '0;
        end
        else if (32'(nsteps_reg) > MAX_STEPS)
        begin
            ns_m1 = STEP_W'(MAX_STEPS - 1);
        end
        else
        begin
            ns_m1 = STEP_W'(nsteps_reg - 5'd1);
        end
    end

    // ceiling of pattern count, then garbage row offset
    always_comb
    begin
        p_full     = {1'b0, div_rsp.quotient[15:0]} + 17'(div_rsp.remainder != '0);
        p_adj      = p_full + 17'(garb_reg);
        p_range_ok = (p_adj < 17'(msize_reg)) && (32'(p_adj) < MAX_STATES);
    end

    always_comb
    begin
        wr_en = accept && (cmd.opcode == OP_WRITE)
                && (32'(cmd.entry_step) < MAX_STEPS)
                && (32'(cmd.entry_row) < MAX_STATES);
        waddr = {STEP_W'(cmd.entry_step), ROW_W'(cmd.entry_row), cmd.entry_col};
    end

    always_comb
    begin
        mag = (rdata >= lo_reg) ? rdata - lo_reg : lo_reg - rdata;
        q16 = div_rsp.quotient[Q_W-1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        pat_next    = pat_reg;
        w_next      = w_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        lostep_next = lostep_reg;
        frac_next   = frac_reg;
        lo_next     = lo_reg;
        neg_next    = neg_reg;
        div_req     = '0;
        mul_req     = '0;
        raddr       = {STEP_W'(lostep_reg + 1'b1), row_reg, col_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.opcode == OP_WRITE)
                    begin
                        done_next   = 1'b1;
                        result_next = '{probability: '0, status: ST_WACK};
                    end
                    else
                    begin
                        pat_next         = cmd.pattern_left;
                        div_req.go       = 1'b1;
                        div_req.dividend = cmd.window_left;
                        div_req.divisor  = dv;
                        state_next       = S_DIVW;
                    end
                end
            end
            S_DIVW:
            begin
                if (div_rsp.done)
                begin
                    w_next           = div_rsp.quotient;
                    div_req.go       = 1'b1;
                    div_req.dividend = DVD_W'(pat_reg);
                    div_req.divisor  = dv;
                    state_next       = S_DIVP;
                end
            end
            S_DIVP:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    if (p_full == '0)
                    begin
                        result_next = '{probability: ONE_Q15, status: ST_OK};
                    end
                    else if (w_reg == '0)
                    begin
                        result_next = '{probability: '0, status: ST_OK};
                    end
                    else if (!p_range_ok)
                    begin
                        result_next = '{probability: '0, status: ST_RANGE};
                    end
                    else if (!loaded_reg)
                    begin
                        result_next = '{probability: '0, status: ST_OK};
                    end
                    else
                    begin
                        done_next        = 1'b0;
                        row_next         = p_adj[ROW_W-1:0];
                        col_next         = garb_reg;
                        div_req.go       = 1'b1;
                        div_req.dividend = w_reg - 1'b1;
                        div_req.divisor  = sz;
                        state_next       = S_DIVL;
                    end
                end
            end
            S_DIVL:
            begin
                if (div_rsp.done)
                begin
                    frac_next   = div_rsp.remainder;
                    lostep_next = div_rsp.quotient[STEP_W-1:0];
                    if (div_rsp.quotient >= DVD_W'(ns_m1))
                    begin
                        raddr      = {ns_m1, row_reg, col_reg};
                        state_next = S_RDLAST;
                    end
                    else
                    begin
                        raddr      = {div_rsp.quotient[STEP_W-1:0], row_reg, col_reg};
                        state_next = S_RDLO;
                    end
                end
            end
            S_RDLAST:
            begin
                done_next   = 1'b1;
                result_next = '{probability: rdata, status: ST_OK};
                state_next  = S_IDLE;
            end
            S_RDLO:
            begin
                lo_next    = rdata;
                state_next = S_RDUP;
            end
            S_RDUP:
            begin
                neg_next   = rdata < lo_reg;
                mul_req.go = 1'b1;
                mul_req.a  = mag;
                mul_req.b  = frac_reg;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (mul_rsp.done)
                begin
                    div_req.go       = 1'b1;
                    div_req.dividend = mul_rsp.product;
                    div_req.divisor  = sz;
                    state_next       = S_DIVI;
                end
            end
            S_DIVI:
            begin
                if (div_rsp.done)
                begin
                    done_next   = 1'b1;
                    result_next = '{probability: neg_reg ? lo_reg - q16 : lo_reg + q16,
                                    status: ST_OK};
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            loaded_reg <= 1'b0;
            div_reg    <= 16'd1;
            step_reg   <= 16'd1;
            nsteps_reg <= 5'd1;
            garb_reg   <= 1'b0;
            msize_reg  <= 7'd1;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (accept && (cmd.opcode == OP_WRITE))
            begin
                loaded_reg <= 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DIV:   div_reg    <= cfg_data;
                    CFG_STEP:  step_reg   <= cfg_data;
                    CFG_NSTEP: nsteps_reg <= cfg_data[4:0];
                    CFG_GARB:  garb_reg   <= cfg_data[0];
                    CFG_MSIZE: msize_reg  <= cfg_data[6:0];
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        pat_reg    <= pat_next;
        w_reg      <= w_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        lostep_reg <= lostep_next;
        frac_reg   <= frac_next;
        lo_reg     <= lo_next;
        neg_reg    <= neg_next;
    end

    // a query holds the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.opcode == OP_QUERY) |=> busy)
        else $error("query accepted but block not busy");

    // a write answers in the next cycle with an acknowledge
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.opcode == OP_WRITE) |=> (done && result.status == ST_WACK))
        else $error("write not acknowledged");

    // range errors carry a zero probability
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_RANGE) |-> (result.probability == '0))
        else $error("range error with nonzero probability");

    // the final division ends the query with a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVI && div_rsp.done) |=> (done && !busy))
        else $error("interpolation finished without result");

    // the serial units never finish at the same time
    assert property (@(posedge clk) disable iff (!rst_n)
        !(div_rsp.done && mul_rsp.done))
        else $error("divider and multiplier both done");

endmodule

// ===== tb/probability_checker.sv =====
// checker: predicts each result word of the lookup and compares it with the block
module probability_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  mpl_pkg::in_t                  cmd,
    input  logic                          done,
    input  mpl_pkg::out_t                 result,
    input  logic                          cfg_we,
    input  logic [mpl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mpl_pkg::CFG_W-1:0]     cfg_data,
    output int                            errors,
    output int                            pending
);
    import mpl_pkg::*;

    logic [Q_W-1:0] power_entries [DEPTH];
    logic           loaded;
    logic [15:0]    div_factor;
    logic [15:0]    step_size;
    logic [4:0]     num_steps;
    logic           garbage_state;
    logic [6:0]     matrix_size;
    out_t           expected_words [$];
    out_t           want;
    int             fail_count = 0;

    assign errors = fail_count;

    function automatic logic [Q_W-1:0] entry(longint unsigned step, longint unsigned row,
                                             logic col);
        return power_entries[(step * MAX_STATES + row) * 2 + col];
    endfunction

    function automatic out_t lookup_probability(in_t w);
        out_t            r;
        longint unsigned dv;
        longint unsigned sz;
        longint unsigned ns;
        longint unsigned win;
        longint unsigned pat;
        longint unsigned lo_i;
        longint          lo;
        longint          up;
        longint          frac;
        logic            col;
        int              addr;
        r = '0;
        col = 1'b0;
        if (w.opcode == OP_WRITE)
        begin
            addr = (int'(w.entry_step) * MAX_STATES + int'(w.entry_row)) * 2
                   + int'(w.entry_col);
            power_entries[addr] = w.entry_value;
            loaded = 1'b1;
            r.status = ST_WACK;
        end
        else
        begin
            dv = (div_factor == 0) ? 1 : div_factor;
            sz = (step_size == 0) ? 1 : step_size;
            ns = (num_steps == 0) ? 1 : num_steps;
            if (ns > MAX_STEPS)
                ns = MAX_STEPS;
            win = w.window_left;
            pat = w.pattern_left;
            win = win / dv;
            pat = (pat + dv - 1) / dv;
            if (pat == 0)
                r.probability = ONE_Q15;
            else if (win == 0)
                r.probability = '0;
            else
            begin
                if (garbage_state)
                begin
                    pat++;
                    col = 1'b1;
                end
                if (pat >= matrix_size || pat >= MAX_STATES)
                    r.status = ST_RANGE;
                else if (!loaded)
                    r.probability = '0;
                else if (win >= 1 + (ns - 1) * sz)
                    r.probability = entry(ns - 1, pat, col);
                else
                begin
                    // linear blend between neighboring steps, truncating toward zero
                    lo_i = (win - 1) / sz;
                    frac = longint'((win - 1) % sz);
                    lo = longint'(entry(lo_i, pat, col));
                    up = longint'(entry(lo_i + 1, pat, col));
                    r.probability = Q_W'(lo + ((up - lo) * frac) / longint'(sz));
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded = 1'b0;
            div_factor = 16'd1;
            step_size = 16'd1;
            num_steps = 5'd1;
            garbage_state = 1'b0;
            matrix_size = 7'd1;
            expected_words.delete();
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word: probability %0d status %0d",
                             $time, result.probability, result.status);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (result.probability !== want.probability)
                    begin
                        $display("%0t: probability expected %0d actual %0d",
                                 $time, want.probability, result.probability);
                        fail_count++;
                    end
                    if (result.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, result.status);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DIV:   div_factor = cfg_data;
                    CFG_STEP:  step_size = cfg_data;
                    CFG_NSTEP: num_steps = cfg_data[4:0];
                    CFG_GARB:  garbage_state = cfg_data[0];
                    CFG_MSIZE: matrix_size = cfg_data[6:0];
                    default:   ;
                endcase
            end
            if (start && !busy)
                expected_words.push_back(lookup_probability(cmd));
            pending <= expected_words.size();
        end
    end

endmodule

// ===== tb/markov_completion_probability_lookup_tb.sv =====
// testbench top: clock, reset, stimulus and verdict for the completion probability lookup
module markov_completion_probability_lookup_tb;
    import mpl_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_MSIZE + 3'd1;
    // only the first rows are filled; queries read no other row
    localparam int FILL_ROWS = 8;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    in_t                  cmd = '0;
    logic                 busy;
    logic                 done;
    out_t                 result;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    int                   errors;
    int                   pending;
    int                   cur_div;
    int                   cur_step;
    int                   cur_nsteps;
    int                   cur_msize;
    logic                 cur_garb;
    bit                   quiet = 1'b0;

    markov_completion_probability_lookup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    probability_checker prob_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return ONE_Q15;
            default: return 16'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic in_t make_noise();
        in_t w;
        w.opcode = 1'($urandom);
        w.window_left = $urandom;
        w.pattern_left = 16'($urandom);
        w.entry_step = 4'($urandom);
        w.entry_row = 6'($urandom);
        w.entry_col = 1'($urandom);
        w.entry_value = 16'($urandom);
        return w;
    endfunction

    function automatic in_t make_write();
        in_t w;
        w = make_noise();
        w.opcode = OP_WRITE;
        w.entry_value = pick_value();
        return w;
    endfunction

    function automatic in_t make_query();
        in_t             w;
        longint unsigned dv;
        longint unsigned sz;
        longint unsigned ns;
        longint unsigned ms;
        longint unsigned lim;
        longint unsigned garb;
        longint unsigned reach;
        longint unsigned tgt;
        longint unsigned val;
        w = make_noise();
        w.opcode = OP_QUERY;
        dv = (cur_div == 0) ? 1 : cur_div;
        sz = (cur_step == 0) ? 1 : cur_step;
        ns = (cur_nsteps == 0) ? 1 : cur_nsteps;
        if (ns > MAX_STEPS)
            ns = MAX_STEPS;
        reach = 1 + (ns - 1) * sz;
        ms = (cur_msize > MAX_STATES) ? MAX_STATES : cur_msize;
        lim = (ms < FILL_ROWS) ? ms : FILL_ROWS;
        garb = 64'(cur_garb);
        case ($urandom_range(0, 15))
            0:       tgt = 0;
            1, 2:    tgt = reach + $urandom_range(0, 3);
            3:       tgt = w.window_left / dv;
            default: tgt = (reach > 1) ? $urandom_range(1, 32'(reach - 1)) : 1;
        endcase
        val = tgt * dv + $urandom_range(0, 32'(dv - 1));
        w.window_left = (val > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : val[31:0];
        case ($urandom_range(0, 7))
            0:       tgt = 0;
            1:       tgt = ms + 1;
            2:       tgt = (ms > garb) ? ms - garb : ms + 1;
            default: tgt = (lim > garb + 1) ? $urandom_range(1, 32'(lim - 1 - garb)) : ms + 1;
        endcase
        if (tgt == 0)
            w.pattern_left = '0;
        else
        begin
            val = (tgt - 1) * dv + $urandom_range(1, 32'(dv));
            if (val <= 64'hFFFF)
                w.pattern_left = val[15:0];
        end
        return w;
    endfunction

    task automatic send_word(in_t w);
        if (!quiet && $urandom_range(0, 99) < 7)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_entry(int step, int row, int col, logic [15:0] value);
        in_t w;
        w = make_noise();
        w.opcode = OP_WRITE;
        w.entry_step = 4'(step);
        w.entry_row = 6'(row);
        w.entry_col = 1'(col);
        w.entry_value = value;
        send_word(w);
    endtask

    task automatic ask(logic [31:0] window, logic [15:0] pattern);
        in_t w;
        w = make_noise();
        w.opcode = OP_QUERY;
        w.window_left = window;
        w.pattern_left = pattern;
        send_word(w);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic set_config(int dv, int sz, int ns, logic garb, int ms);
        wait_drained();
        cur_div = dv;
        cur_step = sz;
        cur_nsteps = ns;
        cur_garb = garb;
        cur_msize = ms;
        // narrow registers get random upper bits, which must be dropped
        write_reg(CFG_DIV, 16'(dv));
        write_reg(CFG_STEP, 16'(sz));
        write_reg(CFG_NSTEP, (16'($urandom) << 5) | 16'(ns));
        write_reg(CFG_GARB, (16'($urandom) << 1) | 16'(garb));
        write_reg(CFG_MSIZE, (16'($urandom) << 7) | 16'(ms));
        write_reg(CFG_SPARE + 3'($urandom_range(0, 2)), 16'($urandom));
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_config(1, 4, 4, 1'b0, 8);

        // empty table
        ask(10, 0);
        ask(0, 2);
        ask(10, 8);
        ask(10, 3);
        ask(32'hFFFF_FFFF, 16'hFFFF);

        for (int s = 0; s < MAX_STEPS; s++)
            for (int r = 0; r < FILL_ROWS; r++)
                for (int c = 0; c < 2; c++)
                    write_entry(s, r, c, pick_value());

        write_entry(0, 1, 0, ONE_Q15);
        write_entry(1, 1, 0, 16'd0);
        write_entry(2, 1, 0, 16'd100);
        write_entry(3, 1, 0, ONE_Q15);
        write_entry(0, 2, 0, 16'd5);
        write_entry(1, 2, 0, 16'd0);
        ask(1, 1);
        ask(3, 1);
        ask(7, 1);
        ask(12, 1);
        ask(13, 1);
        ask(2, 2);
        ask(32'hFFFF_FFFF, 7);
        ask(0, 0);

        for (int ph = 0; ph < 10; ph++)
        begin
            start <= 1'b0;
            case (ph)
                0:       set_config(1, 1, 16, 1'b0, 64);
                1:       set_config(0, 0, 0, 1'b1, 64);
                2:       set_config(3, 5, 31, 1'b1, 10);
                3:       set_config(65535, 65535, 16, 1'b0, 64);
                4:       set_config(2, 65535, 2, 1'b1, 0);
                5:       set_config(7, 3, 5, 1'b0, 100);
                default: set_config($urandom_range(1, 20), $urandom_range(1, 40),
                                    $urandom_range(1, 16), 1'($urandom),
                                    $urandom_range(1, 64));
            endcase
            quiet = (ph == 2);
            repeat (14)
                send_word(($urandom_range(0, 4) == 0) ? make_write() : make_query());
        end
        start <= 1'b0;
        wait_drained();
        repeat (200) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
